### hw/rtl/ttcw_pkg.sv
// Shared types, constants and control/status structs for the text terminal cell writer.
`timescale 1ns / 1ps

package ttcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int ATTR_W    = 4;
    localparam int DATA_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SUBST = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_LOW   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_HIGH  = 8'd126;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 4'd7;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch input fields
        logic bs;         // step back and blank cell
        logic line;       // column 0, next row unless on last row
        logic home;       // cursor to 0,0
        logic put;        // write char at cursor, advance
        logic ptr_clr;    // sweep pointer to 0
        logic scroll_rd;  // read cell one row below pointer
        logic scroll_wr;  // write read data at pointer, advance
        logic fill;       // write blank at pointer, advance
        logic fill_rst;   // blank uses reset attribute
        logic cell_rd;    // read cell at latched index
        logic out_load;   // load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic is_cr;
        logic is_lf;
        logic is_bs;
        logic col_zero;
        logic col_full;
        logic row_last;
        logic ptr_copy_last;
        logic ptr_end;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/ttcw_datapath.sv
// Datapath: screen store, cursor, sweep pointer, attribute and result register.
`timescale 1ns / 1ps

module ttcw_datapath
    import ttcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [OP_W-1:0]      i_op,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [IDX_W-1:0]     i_cell_index,
    input  logic                 i_cfg_valid,
    input  logic [ATTR_W-1:0]    i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [DATA_W-1:0]    o_read_data,
    output logic [ROW_OUT_W-1:0] o_cursor_row,
    output logic [COL_OUT_W-1:0] o_cursor_col
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS + 1);
    localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

    logic [DATA_W-1:0] r_mem [CELLS];
    logic [DATA_W-1:0] r_rdata;

    t_op               r_op;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;
    logic [ATTR_W-1:0] r_attr;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_ptr;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;
    logic [CHAR_W-1:0] put_char;
    logic [ATTR_W-1:0] fill_attr;
    logic              idx_ok;
    logic              row_last;
    logic              out_free;

    function automatic logic [DATA_W-1:0] make_cell(logic [ATTR_W-1:0] attr,
                                                    logic [CHAR_W-1:0] ch);
        return {{(DATA_W - ATTR_W - CHAR_W){1'b0}}, attr, ch};
    endfunction

    assign pos       = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign put_char  = (r_char >= CH_LOW && r_char <= CH_HIGH) ? r_char : CH_SUBST;
    assign fill_attr = i_cmd.fill_rst ? ATTR_RESET : r_attr;
    assign idx_ok    = 32'(r_idx) < 32'(CELLS);
    assign row_last  = r_row == ROW_W'(ROWS - 1);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = make_cell(fill_attr, CH_BLANK);
        if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = pos;
            wr_data = make_cell(r_attr, put_char);
        end else if (i_cmd.bs) begin
            wr_en   = 1'b1;
            wr_addr = pos - ADDR_W'(1);
            wr_data = make_cell(r_attr, CH_BLANK);
        end else if (i_cmd.scroll_wr) begin
            wr_en   = 1'b1;
            wr_data = r_rdata;
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
        end
    end

    assign rd_en   = i_cmd.scroll_rd || i_cmd.cell_rd;
    assign rd_addr = i_cmd.scroll_rd ? r_ptr + ADDR_W'(COLUMNS) : ADDR_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
        if (i_cmd.out_load) begin
            r_out_data <= (r_op == OP_READ && idx_ok) ? r_rdata : '0;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= ATTR_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end

            if (i_cmd.home) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.line) begin
                r_col <= '0;
                if (!row_last) begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else if (i_cmd.put) begin
                r_col <= r_col + COL_W'(1);
            end else if (i_cmd.bs) begin
                r_col <= r_col - COL_W'(1);
            end

            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.scroll_wr || i_cmd.fill) begin
                r_ptr <= r_ptr + ADDR_W'(1);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.op            = r_op;
        o_sts.is_cr         = r_char == CH_CR;
        o_sts.is_lf         = r_char == CH_LF;
        o_sts.is_bs         = r_char == CH_BS;
        o_sts.col_zero      = r_col == '0;
        o_sts.col_full      = r_col >= COL_W'(COLUMNS);
        o_sts.row_last      = row_last;
        o_sts.ptr_copy_last = r_ptr == ADDR_W'(COPY_LAST);
        o_sts.ptr_end       = r_ptr == ADDR_W'(CELLS - 1);
        o_sts.out_free      = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_out_data;
    assign o_cursor_row = ROW_OUT_W'(r_out_row);
    assign o_cursor_col = COL_OUT_W'(r_out_col);

endmodule

### hw/rtl/ttcw_controller.sv
// Controller: sequences decode, put, newline, scroll, clear and the post-reset blanking pass.
`timescale 1ns / 1ps

module ttcw_controller
    import ttcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_DECODE,
        S_LINE,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_BLANK,
        S_PUT,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RST_CLR: begin
                o_cmd.fill     = 1'b1;
                o_cmd.fill_rst = 1'b1;
                if (i_sts.ptr_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_PUT: begin
                        if (i_sts.is_cr) begin
                            n_state = S_DONE;
                        end else if (i_sts.is_lf) begin
                            n_state = S_LINE;
                        end else if (i_sts.is_bs) begin
                            o_cmd.bs = !i_sts.col_zero;
                            n_state  = S_DONE;
                        end else if (i_sts.col_full) begin
                            n_state = S_LINE;  // lazy wrap
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    OP_READ: begin
                        o_cmd.cell_rd = 1'b1;
                        n_state       = S_DONE;
                    end
                    OP_CLEAR: begin
                        o_cmd.ptr_clr = 1'b1;
                        o_cmd.home    = 1'b1;
                        n_state       = S_CLEAR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_LINE: begin
                o_cmd.line = 1'b1;
                if (i_sts.row_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_SCROLL_RD;
                end else if (i_sts.is_lf) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_SCROLL_RD: begin
                o_cmd.scroll_rd = 1'b1;
                n_state         = S_SCROLL_WR;
            end
            S_SCROLL_WR: begin
                o_cmd.scroll_wr = 1'b1;
                // pointer lands on the first cell of the bottom row
                n_state = i_sts.ptr_copy_last ? S_BLANK : S_SCROLL_RD;
            end
            S_BLANK: begin
                o_cmd.fill = 1'b1;
                if (i_sts.ptr_end) begin
                    n_state = i_sts.is_lf ? S_DONE : S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.fill = 1'b1;
                if (i_sts.ptr_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

### hw/rtl/text_terminal_cell_writer_top.sv
// Top level of the text terminal cell writer: controller, datapath and checks.
//
//  channel  direction  handshake                    payload
//  in       to block   i_in_valid / o_in_stall      i_op, i_char_code, i_cell_index
//  out      from block o_out_valid / i_out_stall    o_read_data, o_cursor_row, o_cursor_col
//  cfg      to block   i_cfg_valid / o_cfg_ready    i_cfg_data (attribute)
//
// One item at a time; a new transfer is taken once the previous result is in the output
// register. A wrap or a newline on the last row scrolls the screen up one row, copying each
// cell from the row below and then blanking the bottom row; clear blanks every cell with the
// current attribute and homes the cursor. After reset a blanking pass of all ROWS*COLUMNS
// cells runs with input stalled; cfg is always ready. A stalled output holds its result;
// the block waits in its last step until taken.
`timescale 1ns / 1ps

module text_terminal_cell_writer_top
    import ttcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [IDX_W-1:0]     i_cell_index,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_read_data,
    output logic [ROW_OUT_W-1:0] o_cursor_row,
    output logic [COL_OUT_W-1:0] o_cursor_col,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ATTR_W-1:0]    i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ttcw_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    ttcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_read_data  (o_read_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    // one writer of the screen store per cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.put, cmd.bs, cmd.scroll_wr, cmd.fill}))
        else $error("more than one screen write in a cycle");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // scroll write always follows its read
    a_scroll_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scroll_wr |-> $past(cmd.scroll_rd))
        else $error("scroll write without preceding read");

    // no transfer accepted while a scroll or clear sweep runs
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.fill || cmd.scroll_rd || cmd.scroll_wr) |-> o_in_stall)
        else $error("input taken during sweep");

endmodule
